FILE: hw/rtl/hsps_pkg.sv
package hsps_pkg;

	// Bus request codes carried by each result word.
	localparam logic [1:0] REQ_NONE  = 2'd0;
	localparam logic [1:0] REQ_PROBE = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	// Sensor command bytes.
	localparam logic [7:0] CMD_MEAS_T = 8'hF3;
	localparam logic [7:0] CMD_MEAS_H = 8'hF5;
	localparam logic [7:0] CMD_RESET  = 8'hFE;
	localparam logic [7:0] CMD_NONE   = 8'h00;

	// Event codes on the input channel.
	localparam logic EVT_TICK     = 1'b0;
	localparam logic EVT_RESPONSE = 1'b1;

	// Configuration register indexes and port widths.
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_POLL_PERIOD = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_STEP_DELAY  = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEV_ADDR    = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_BUS_CHANNEL = 8'd3;

	// Configuration reset values.
	localparam logic [15:0] POLL_PERIOD_RST = 16'd1000;
	localparam logic [7:0]  STEP_DELAY_RST  = 8'd40;

	// Fixed-point conversion: floor(scale * raw / 65536) - offset, 15-bit result.
	localparam int VALUE_W = 15;
	localparam int RAW_W   = 16;
	localparam int SCALE_W = 15;
	localparam logic [SCALE_W-1:0] TEMP_SCALE  = 15'd17572;
	localparam logic [VALUE_W-1:0] TEMP_OFFSET = 15'd4685;
	localparam logic [SCALE_W-1:0] HUM_SCALE   = 15'd12500;
	localparam logic [VALUE_W-1:0] HUM_OFFSET  = 15'd600;

endpackage

FILE: hw/rtl/hsps_if.sv
// Input channel: millisecond ticks and bus master responses.
interface hsps_evt_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic       bus_ok;
	logic [7:0] data_high;
	logic [7:0] data_low;

	modport source (output valid, cmd, bus_ok, data_high, data_low, input ready);
	modport sink   (input valid, cmd, bus_ok, data_high, data_low, output ready);
endinterface

// Result channel: bus requests, stored readings and status.
interface hsps_res_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           bus_request;
	logic [7:0]                           command_byte;
	logic signed [hsps_pkg::VALUE_W-1:0]  temperature_centi;
	logic signed [hsps_pkg::VALUE_W-1:0]  humidity_centi;
	logic                                 reading_valid;
	logic                                 error_flag;
	logic                                 cycle_done;

	modport source (output valid, bus_request, command_byte, temperature_centi,
		humidity_centi, reading_valid, error_flag, cycle_done, input ready);
	modport sink   (input valid, bus_request, command_byte, temperature_centi,
		humidity_centi, reading_valid, error_flag, cycle_done, output ready);
endinterface

// Configuration write channel.
interface hsps_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [hsps_pkg::CFG_INDEX_W-1:0]   index;
	logic [hsps_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/hsps_convert.sv
// Converts a raw 16-bit sensor reading to hundredths, for temperature or humidity.
module hsps_convert (
	input  logic [hsps_pkg::RAW_W-1:0]          raw,
	input  logic                                sel_humidity,
	output logic signed [hsps_pkg::VALUE_W-1:0] value
);

	localparam int PROD_W = hsps_pkg::RAW_W + hsps_pkg::SCALE_W;

	logic [hsps_pkg::SCALE_W-1:0] scale;
	logic [hsps_pkg::VALUE_W-1:0] offset;
	logic [PROD_W-1:0]            product;
	logic [hsps_pkg::VALUE_W-1:0] scaled;

	// One shared multiplier; the coefficients are picked by the reading in hand.
	always_comb begin
		scale   = sel_humidity ? hsps_pkg::HUM_SCALE : hsps_pkg::TEMP_SCALE;
		offset  = sel_humidity ? hsps_pkg::HUM_OFFSET : hsps_pkg::TEMP_OFFSET;
		product = PROD_W'(raw) * PROD_W'(scale);
		scaled  = product[PROD_W-1:hsps_pkg::RAW_W];
		value   = $signed(scaled - offset);
	end

endmodule

FILE: hw/rtl/humidity_sensor_poll_sequencer_top.sv
// Poll sequencer for a temperature and humidity sensor behind an external I2C master.
// The events channel carries one word per millisecond tick (cmd 0) or per bus
// response to the last request (cmd 1, with bus_ok and the two data bytes read).
// Every event word yields exactly one result word on the results channel: the next
// bus request (none, probe, write command_byte, read the data bytes), the stored
// temperature and humidity in hundredths, and the valid, error and done flags.
// The cfg channel writes the poll period and step delay; it is always ready and
// should only be written while no event word is in flight. Indexes two and three
// (device address, bus channel) are accepted and leave the sequence unchanged.
// An accepted event word is loaded into the input register; when it advances, the
// result register is loaded from it through the sequencing logic and the single
// 16 by 15 bit conversion multiplier.
// Throughput is one word per cycle while the receiver takes results.
// When the receiver stalls, the result register holds its word, the input
// register still takes one more word, and then events.ready drops until the
// result is taken. Reset empties both registers, clears the readings and flags,
// restores the configuration defaults and starts from the probe step.
module humidity_sensor_poll_sequencer_top #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	hsps_evt_if.sink   events,
	hsps_res_if.source results,
	hsps_cfg_if.sink   cfg
);

	localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

	typedef enum logic [2:0] {
		PH_DETECT = 3'd0,
		PH_RESET  = 3'd1,
		PH_MEAS_T = 3'd2,
		PH_READ_T = 3'd3,
		PH_MEAS_H = 3'd4,
		PH_READ_H = 3'd5,
		PH_WAIT   = 3'd6
	} phase_t;

	// Configuration registers.
	logic [15:0] poll_period_q;
	logic [7:0]  step_delay_q;

	// Input register.
	logic       valid_s1;
	logic       cmd_s1;
	logic       bus_ok_s1;
	logic [15:0] raw_s1;

	// Sequencer state.
	phase_t                          phase_q, phase_d;
	logic                            await_q, await_d;
	logic [TIMER_WIDTH-1:0]          step_q, step_d;
	logic [TIMER_WIDTH-1:0]          cycle_q, cycle_d;
	logic signed [hsps_pkg::VALUE_W-1:0] temp_q, temp_d;
	logic signed [hsps_pkg::VALUE_W-1:0] hum_q, hum_d;
	logic                            rvalid_q, rvalid_d;
	logic                            error_q, error_d;

	// Result register.
	logic                            out_valid_q;
	logic [1:0]                      req_q, req_d;
	logic [7:0]                      cbyte_q, cbyte_d;
	logic                            done_q, done_d;

	logic                            advance;
	logic                            step_ready;
	logic signed [hsps_pkg::VALUE_W-1:0] conv_value;

	assign advance      = valid_s1 && (!out_valid_q || results.ready);
	assign events.ready = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;

	// Conversion of the reading carried by the current response word.
	hsps_convert u_convert (
		.raw          (raw_s1),
		.sel_humidity (phase_q == PH_READ_H),
		.value        (conv_value)
	);

	// Configuration writes; indexes beyond the step delay change nothing here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_period_q <= hsps_pkg::POLL_PERIOD_RST;
			step_delay_q  <= hsps_pkg::STEP_DELAY_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				hsps_pkg::CFG_POLL_PERIOD: poll_period_q <= cfg.data[15:0];
				hsps_pkg::CFG_STEP_DELAY:  step_delay_q  <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// Next state and result for the word in the input register.
	always_comb begin
		phase_d    = phase_q;
		await_d    = await_q;
		step_d     = step_q;
		cycle_d    = cycle_q;
		temp_d     = temp_q;
		hum_d      = hum_q;
		rvalid_d   = rvalid_q;
		error_d    = error_q;
		req_d      = hsps_pkg::REQ_NONE;
		cbyte_d    = hsps_pkg::CMD_NONE;
		done_d     = 1'b0;
		step_ready = 1'b0;

		if (cmd_s1 == hsps_pkg::EVT_TICK) begin
			// Both timers count up and stick at their maximum.
			step_d  = (step_q == '1) ? step_q : step_q + 1'b1;
			cycle_d = (cycle_q == '1) ? cycle_q : cycle_q + 1'b1;
			step_ready = CMP_W'(step_d) >= CMP_W'(step_delay_q);
			if (!await_q) begin
				case (phase_q)
					PH_MEAS_T: begin
						if (step_ready) begin
							req_d   = hsps_pkg::REQ_WRITE;
							cbyte_d = hsps_pkg::CMD_MEAS_T;
							await_d = 1'b1;
						end
					end
					PH_MEAS_H: begin
						if (step_ready) begin
							req_d   = hsps_pkg::REQ_WRITE;
							cbyte_d = hsps_pkg::CMD_MEAS_H;
							await_d = 1'b1;
						end
					end
					PH_READ_T, PH_READ_H: begin
						if (step_ready) begin
							req_d   = hsps_pkg::REQ_READ;
							await_d = 1'b1;
						end
					end
					PH_WAIT: begin
						if (CMP_W'(cycle_d) >= CMP_W'(poll_period_q)) begin
							phase_d = PH_DETECT;
						end
					end
					default: begin
						// Detect, reset and unknown codes all start with a probe.
						req_d   = hsps_pkg::REQ_PROBE;
						phase_d = PH_DETECT;
						cycle_d = '0;
						await_d = 1'b1;
					end
				endcase
			end
		end else if (await_q) begin
			await_d = 1'b0;
			if (!bus_ok_s1) begin
				// A failed transaction drops the reading and waits a full period.
				error_d  = 1'b1;
				rvalid_d = 1'b0;
				step_d   = '0;
				cycle_d  = '0;
				phase_d  = PH_WAIT;
			end else begin
				case (phase_q)
					PH_RESET: begin
						error_d = 1'b0;
						step_d  = '0;
						phase_d = PH_MEAS_T;
					end
					PH_MEAS_T: begin
						error_d = 1'b0;
						step_d  = '0;
						phase_d = PH_READ_T;
					end
					PH_MEAS_H: begin
						error_d = 1'b0;
						step_d  = '0;
						phase_d = PH_READ_H;
					end
					PH_READ_T: begin
						temp_d  = conv_value;
						step_d  = '0;
						phase_d = PH_MEAS_H;
					end
					PH_READ_H: begin
						hum_d    = conv_value;
						rvalid_d = 1'b1;
						done_d   = 1'b1;
						phase_d  = PH_WAIT;
					end
					PH_WAIT: ;
					default: begin
						// Probe answered: issue the soft reset at once.
						phase_d = PH_RESET;
						req_d   = hsps_pkg::REQ_WRITE;
						cbyte_d = hsps_pkg::CMD_RESET;
						await_d = 1'b1;
					end
				endcase
			end
		end
	end

	// Input register, sequencer state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_DETECT;
			await_q     <= 1'b0;
			step_q      <= '0;
			cycle_q     <= '0;
			temp_q      <= '0;
			hum_q       <= '0;
			rvalid_q    <= 1'b0;
			error_q     <= 1'b0;
			req_q       <= hsps_pkg::REQ_NONE;
			cbyte_q     <= hsps_pkg::CMD_NONE;
			done_q      <= 1'b0;
		end else begin
			if (events.ready) begin
				valid_s1 <= events.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				phase_q     <= phase_d;
				await_q     <= await_d;
				step_q      <= step_d;
				cycle_q     <= cycle_d;
				temp_q      <= temp_d;
				hum_q       <= hum_d;
				rvalid_q    <= rvalid_d;
				error_q     <= error_d;
				req_q       <= req_d;
				cbyte_q     <= cbyte_d;
				done_q      <= done_d;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			cmd_s1    <= events.cmd;
			bus_ok_s1 <= events.bus_ok;
			raw_s1    <= {events.data_high, events.data_low};
		end
	end

	// The stored readings and flags after each word go out with its request.
	assign results.valid             = out_valid_q;
	assign results.bus_request       = req_q;
	assign results.command_byte      = cbyte_q;
	assign results.temperature_centi = temp_q;
	assign results.humidity_centi    = hum_q;
	assign results.reading_valid     = rvalid_q;
	assign results.error_flag        = error_q;
	assign results.cycle_done        = done_q;

`ifndef SYNTHESIS
	a_done_implies_valid: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.cycle_done |-> results.reading_valid)
		else $error("cycle_done without reading_valid");

	a_cbyte_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.bus_request != hsps_pkg::REQ_WRITE)
		|-> results.command_byte == hsps_pkg::CMD_NONE)
		else $error("command byte set on a request other than a write");

	a_no_await_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		!(await_q && (phase_q == PH_WAIT)))
		else $error("response awaited during the poll wait");

	a_valid_error_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(rvalid_q && error_q))
		else $error("reading valid while the error flag is set");

	a_request_sets_await: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (req_d != hsps_pkg::REQ_NONE) |=> await_q)
		else $error("request issued without awaiting a response");
`endif

endmodule
